### hw/rtl/lkc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkc_pkg
// shared types and constants of the lru-k block cache directory
// ----------------------------------------------------------------------------
package lkc_pkg;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_CAPACITY  = 1'b1;

    localparam logic [3:0] THRESHOLD_RESET = 4'd2;
    localparam logic [3:0] THRESHOLD_MIN   = 4'd2;
    localparam logic [6:0] CAPACITY_RESET  = 7'd64;

    typedef struct packed {
        logic        command;
        logic [30:0] sst_id;
        logic [30:0] blk_num;
        logic [31:0] block_handle;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [31:0] found_handle;
        logic [31:0] request_total;
        logic [31:0] request_hits;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic scan;
        logic exec;
        logic evict;
        logic insert;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_issue;
        logic put_miss;
        logic need_evict;
    } t_dp_sts;

endpackage

### hw/rtl/lru_k_block_cache_policy.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_k_block_cache_policy
// fully associative block cache directory with lru-k two-queue replacement
// ----------------------------------------------------------------------------
// one request at a time. a request scans the key memory one slot per cycle;
// a get or an update then executes and responds, an insert into a free slot
// adds an insert step and an insert that evicts adds an evict step before
// it. busy is high for the whole request; the result appears for exactly
// one cycle on o_rsp_valid and cannot be held off. configuration writes are
// accepted only while idle and take effect on the next request.
module lru_k_block_cache_policy #(
    parameter int ENTRIES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  lkc_pkg::t_req i_req,
    output logic          o_rsp_valid,
    output lkc_pkg::t_rsp o_rsp,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_index,
    input  logic [6:0]    i_cfg_data
);
    lkc_pkg::t_dp_cmd cmd;
    lkc_pkg::t_dp_sts sts;

    assign o_cfg_ready = !busy;

    lkc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .o_rsp_valid (o_rsp_valid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    lkc_datapath #(.ENTRIES(ENTRIES)) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );
endmodule

### hw/rtl/lkc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkc_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module lkc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/lkc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkc_datapath
// key and handle memories, per-slot rank lanes, scan accumulators, counters
// ----------------------------------------------------------------------------
module lkc_datapath #(
    parameter int ENTRIES = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lkc_pkg::t_req    i_req,
    input  lkc_pkg::t_dp_cmd i_cmd,
    output lkc_pkg::t_dp_sts o_sts,
    output lkc_pkg::t_rsp    o_rsp,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [6:0]       i_cfg_data
);
    localparam int IW = $clog2(ENTRIES);
    localparam int UW = $clog2(ENTRIES + 1);

    lkc_pkg::t_req r_req;
    logic [3:0]    r_thr;
    logic [6:0]    r_cap;

    logic          r_valid [ENTRIES];
    logic [IW-1:0] r_rec   [ENTRIES];
    logic [3:0]    r_cnt   [ENTRIES];

    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_pidx;
    logic          r_cmp_vld;

    logic          r_match_found, r_free_found, r_prob_found, r_any_found;
    logic [IW-1:0] r_match_idx, r_match_rec, r_free_idx;
    logic [IW-1:0] r_prob_idx, r_prob_rec, r_any_idx, r_any_rec;
    logic [UW-1:0] r_used;
    logic          r_evicted;
    logic          r_hit;
    logic [31:0]   r_total, r_hits;

    logic [61:0]   key_rdata;
    logic [31:0]   handle_rdata;
    logic [3:0]    eff_k;
    logic [31:0]   eff_cap, used32;
    logic          p_valid, p_prob, p_match;
    logic [IW-1:0] p_rec;
    logic [IW-1:0] vic_idx, vic_rec, ins_slot;
    logic          ins_ok, is_get;
    logic          h_we, h_re;
    logic [IW-1:0] h_waddr;

    always_comb begin
        eff_k = (r_thr < lkc_pkg::THRESHOLD_MIN) ? lkc_pkg::THRESHOLD_MIN : r_thr;
        if (r_cap == 7'd0) begin
            eff_cap = 32'd1;
        end else if (32'(r_cap) > 32'(ENTRIES)) begin
            eff_cap = 32'(ENTRIES);
        end else begin
            eff_cap = 32'(r_cap);
        end
        used32 = 32'(r_used);
        is_get = (r_req.command == lkc_pkg::CMD_GET);
    end

    // compare stage of the scan, one slot per cycle
    always_comb begin
        p_valid = r_valid[r_pidx];
        p_rec   = r_rec[r_pidx];
        p_prob  = p_valid && (r_cnt[r_pidx] < eff_k);
        p_match = p_valid && (key_rdata == {r_req.sst_id, r_req.blk_num});
    end

    always_comb begin
        vic_idx = r_prob_found ? r_prob_idx : r_any_idx;
        vic_rec = r_prob_found ? r_prob_rec : r_any_rec;
        if (r_evicted) begin
            ins_ok   = 1'b1;
            ins_slot = (r_free_found && (r_free_idx < vic_idx)) ? r_free_idx : vic_idx;
        end else begin
            ins_ok   = r_free_found;
            ins_slot = r_free_idx;
        end
    end

    assign o_sts.last_issue = i_cmd.scan && (r_idx == IW'(ENTRIES - 1));
    assign o_sts.put_miss   = !is_get && !r_match_found;
    assign o_sts.need_evict = (used32 >= eff_cap) && (r_prob_found || r_any_found);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= lkc_pkg::THRESHOLD_RESET;
            r_cap <= lkc_pkg::CAPACITY_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == lkc_pkg::CFG_THRESHOLD) begin
                r_thr <= i_cfg_data[3:0];
            end else begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_req <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx         <= '0;
            r_cmp_vld     <= 1'b0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_prob_found  <= 1'b0;
            r_any_found   <= 1'b0;
            r_used        <= '0;
            r_evicted     <= 1'b0;
        end else if (i_cmd.clear) begin
            r_idx         <= '0;
            r_cmp_vld     <= 1'b0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_prob_found  <= 1'b0;
            r_any_found   <= 1'b0;
            r_used        <= '0;
            r_evicted     <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan;
            if (i_cmd.scan) begin
                r_idx  <= r_idx + 1'b1;
                r_pidx <= r_idx;
            end
            if (i_cmd.evict) begin
                r_evicted <= 1'b1;
            end
            if (r_cmp_vld) begin
                if (p_match) begin
                    r_match_found <= 1'b1;
                    r_match_idx   <= r_pidx;
                    r_match_rec   <= p_rec;
                end
                if (!p_valid && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_pidx;
                end
                if (p_valid) begin
                    r_used <= r_used + 1'b1;
                end
                if (p_prob && (!r_prob_found || p_rec > r_prob_rec)) begin
                    r_prob_found <= 1'b1;
                    r_prob_idx   <= r_pidx;
                    r_prob_rec   <= p_rec;
                end
                if (p_valid && (!r_any_found || p_rec > r_any_rec)) begin
                    r_any_found <= 1'b1;
                    r_any_idx   <= r_pidx;
                    r_any_rec   <= p_rec;
                end
            end
        end
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_lane
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
                r_rec[g]   <= '0;
            end else if (i_cmd.exec && r_match_found) begin
                if (r_match_idx == IW'(g)) begin
                    r_rec[g] <= '0;
                    r_cnt[g] <= (r_cnt[g] < eff_k) ? r_cnt[g] + 4'd1 : eff_k;
                end else if (r_valid[g] && r_rec[g] < r_match_rec) begin
                    r_rec[g] <= r_rec[g] + 1'b1;
                end
            end else if (i_cmd.evict) begin
                if (vic_idx == IW'(g)) begin
                    r_valid[g] <= 1'b0;
                end else if (r_valid[g] && r_rec[g] > vic_rec) begin
                    r_rec[g] <= r_rec[g] - 1'b1;
                end
            end else if (i_cmd.insert) begin
                if (ins_ok && ins_slot == IW'(g)) begin
                    r_valid[g] <= 1'b1;
                    r_rec[g]   <= '0;
                    r_cnt[g]   <= 4'd1;
                end else if (r_valid[g]) begin
                    r_rec[g] <= r_rec[g] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_hits  <= '0;
            r_hit   <= 1'b0;
        end else if (i_cmd.exec) begin
            r_hit <= is_get && r_match_found;
            if (is_get) begin
                if (r_total != '1) begin
                    r_total <= r_total + 32'd1;
                end
                if (r_match_found && r_hits != '1) begin
                    r_hits <= r_hits + 32'd1;
                end
            end
        end
    end

    assign h_re    = i_cmd.exec && is_get && r_match_found;
    assign h_we    = (i_cmd.exec && !is_get && r_match_found) || (i_cmd.insert && ins_ok);
    assign h_waddr = i_cmd.insert ? ins_slot : r_match_idx;

    lkc_ram #(.WIDTH(62), .DEPTH(ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.insert && ins_ok),
        .i_waddr (ins_slot),
        .i_wdata ({r_req.sst_id, r_req.blk_num}),
        .i_re    (i_cmd.scan),
        .i_raddr (r_idx),
        .o_rdata (key_rdata)
    );

    lkc_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_handle_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (r_req.block_handle),
        .i_re    (h_re),
        .i_raddr (r_match_idx),
        .o_rdata (handle_rdata)
    );

    assign o_rsp.hit           = r_hit;
    assign o_rsp.found_handle  = r_hit ? handle_rdata : 32'd0;
    assign o_rsp.request_total = r_total;
    assign o_rsp.request_hits  = r_hits;

    a_evict_has_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.evict |-> (r_prob_found || r_any_found))
        else $error("eviction without a victim");

    a_touch_to_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_match_found) |=> (r_rec[r_match_idx] == '0))
        else $error("touched slot not most recent");

    a_hits_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> (r_hits <= r_total))
        else $error("hit count above request count");

    a_insert_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.insert && ins_ok) |=> r_valid[$past(ins_slot)])
        else $error("inserted slot not valid");
endmodule

### hw/rtl/lkc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkc_ctrl
// request sequencer: scan, drain, execute, evict, insert, respond
// ----------------------------------------------------------------------------
module lkc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    output logic             o_rsp_valid,
    output lkc_pkg::t_dp_cmd o_cmd,
    input  lkc_pkg::t_dp_sts i_sts
);
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_DRAIN  = 7'b0000100,
        S_EXEC   = 7'b0001000,
        S_EVICT  = 7'b0010000,
        S_INSERT = 7'b0100000,
        S_RESP   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_EXEC;
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.put_miss) begin
                    n_state = i_sts.need_evict ? S_EVICT : S_INSERT;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_EVICT: begin
                o_cmd.evict = 1'b1;
                n_state     = S_INSERT;
            end
            S_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = S_RESP;
            end
            S_RESP:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_rsp_valid = (r_state == S_RESP);

    a_resp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |=> !o_busy)
        else $error("response not followed by idle");

    a_start_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_state == S_SCAN))
        else $error("accepted request did not start a scan");

    a_insert_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.insert |-> ($past(r_state) == S_EXEC || $past(r_state) == S_EVICT))
        else $error("insert out of sequence");
endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the lru-k block cache directory: a directed table
// of requests, then random get/put traffic over a small key pool, checked
// against a behavioral model of the two-queue replacement
// ----------------------------------------------------------------------------
module testbench;

    localparam int ENTRIES  = 64;
    localparam int WD_LIMIT = 20000;
    localparam int N_RANDOM = 1280;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    lkc_pkg::t_req req;
    logic          rsp_valid;
    lkc_pkg::t_rsp rsp;
    logic          cfg_valid;
    logic          cfg_ready;
    logic          cfg_index;
    logic [6:0]    cfg_data;

    lru_k_block_cache_policy #(.ENTRIES(ENTRIES)) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .o_rsp       (rsp),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        clk = 1'b1; #5;
        clk = 1'b0; #5;
    end

    // directory model
    logic        m_valid [ENTRIES];
    logic [30:0] m_table [ENTRIES];
    logic [30:0] m_block [ENTRIES];
    logic [31:0] m_handle[ENTRIES];
    logic [3:0]  m_count [ENTRIES];
    int          m_rank  [ENTRIES];
    logic [31:0] m_total, m_hits;
    logic [3:0]  m_thresh;
    logic [6:0]  m_cap;

    lkc_pkg::t_rsp rsp_queue[$];
    int   errors;
    int   wd_count;
    int   n_gets, n_hits_seen, n_evict_cfg;

    function automatic int eff_k();
        return (m_thresh < lkc_pkg::THRESHOLD_MIN) ? int'(lkc_pkg::THRESHOLD_MIN)
                                                   : int'(m_thresh);
    endfunction

    function automatic int eff_cap();
        if (m_cap < 1) return 1;
        if (m_cap > ENTRIES) return ENTRIES;
        return int'(m_cap);
    endfunction

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic void touch_slot(int s);
        int r;
        r = m_rank[s];
        for (int i = 0; i < ENTRIES; i++)
            if (m_valid[i] && m_rank[i] < r) m_rank[i]++;
        m_rank[s] = 0;
        m_count[s] = (m_count[s] < eff_k()) ? m_count[s] + 4'd1 : 4'(eff_k());
    endfunction

    function automatic void evict_victim();
        int v;
        int r;
        v = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (m_valid[i] && m_count[i] < eff_k() && (v < 0 || m_rank[i] > m_rank[v]))
                v = i;
        if (v < 0)
            for (int i = 0; i < ENTRIES; i++)
                if (m_valid[i] && (v < 0 || m_rank[i] > m_rank[v])) v = i;
        if (v < 0) return;
        r = m_rank[v];
        m_valid[v] = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
            if (m_valid[i] && m_rank[i] > r) m_rank[i]--;
    endfunction

    function automatic lkc_pkg::t_rsp predict_lookup(lkc_pkg::t_req r);
        lkc_pkg::t_rsp o;
        int s, used, fs;
        o = '0;
        s = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (s < 0 && m_valid[i] && m_table[i] == r.sst_id && m_block[i] == r.blk_num)
                s = i;
        if (r.command == lkc_pkg::CMD_GET) begin
            m_total = sat_inc(m_total);
            if (s >= 0) begin
                m_hits = sat_inc(m_hits);
                touch_slot(s);
                o.hit = 1'b1;
                o.found_handle = m_handle[s];
            end
        end else if (s >= 0) begin
            m_handle[s] = r.block_handle;
            touch_slot(s);
        end else begin
            used = 0;
            for (int i = 0; i < ENTRIES; i++) if (m_valid[i]) used++;
            if (used >= eff_cap()) evict_victim();
            fs = -1;
            for (int i = 0; i < ENTRIES; i++) begin
                if (!m_valid[i]) begin
                    if (fs < 0) fs = i;
                end else begin
                    m_rank[i]++;
                end
            end
            if (fs >= 0) begin
                m_valid[fs]  = 1'b1;
                m_table[fs]  = r.sst_id;
                m_block[fs]  = r.blk_num;
                m_handle[fs] = r.block_handle;
                m_count[fs]  = 4'd1;
                m_rank[fs]   = 0;
            end
        end
        o.request_total = m_total;
        o.request_hits  = m_hits;
        return o;
    endfunction

    // result checking
    always @(posedge clk) begin
        lkc_pkg::t_rsp e;
        if (rst_n && rsp_valid) begin
            if (rsp_queue.size() == 0) begin
                $error("unexpected response %h", rsp);
                errors++;
            end else begin
                e = rsp_queue.pop_front();
                if (rsp.hit !== e.hit) begin
                    $error("hit: expected %0d actual %0d", e.hit, rsp.hit);
                    errors++;
                end
                if (rsp.found_handle !== e.found_handle) begin
                    $error("found_handle: expected %h actual %h",
                           e.found_handle, rsp.found_handle);
                    errors++;
                end
                if (rsp.request_total !== e.request_total) begin
                    $error("request_total: expected %0d actual %0d",
                           e.request_total, rsp.request_total);
                    errors++;
                end
                if (rsp.request_hits !== e.request_hits) begin
                    $error("request_hits: expected %0d actual %0d",
                           e.request_hits, rsp.request_hits);
                    errors++;
                end
                if (rsp.hit === 1'b1) n_hits_seen++;
            end
        end
    end

    // watchdog: cycles without any accepted request, configuration write or response
    always @(posedge clk) begin
        if ((start && !busy) || rsp_valid || (cfg_valid && cfg_ready))
            wd_count <= 0;
        else
            wd_count <= wd_count + 1;
        if (wd_count >= WD_LIMIT) begin
            $display("watchdog expired");
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic [6:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == lkc_pkg::CFG_THRESHOLD) m_thresh = val[3:0];
        else m_cap = val;
        @(posedge clk);
    endtask

    task automatic drain_responses();
        while (rsp_queue.size() != 0) @(posedge clk);
        repeat (ENTRIES + 8) @(posedge clk);
    endtask

    // directed rows carry a fixed expectation only where check_fixed is set
    task automatic send_request(lkc_pkg::t_req r, bit check_fixed, lkc_pkg::t_rsp fixed,
                                bit may_idle);
        lkc_pkg::t_rsp p;
        if (may_idle)
            while ($urandom_range(99) < 9) @(posedge clk);
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy) @(posedge clk);
        start <= 1'b0;
        p = predict_lookup(r);
        if (r.command == lkc_pkg::CMD_GET) n_gets++;
        if (check_fixed && p !== fixed) begin
            $error("table row: expected %h model %h", fixed, p);
            errors++;
        end
        rsp_queue.push_back(p);
        @(posedge clk);
    endtask

    typedef struct {
        lkc_pkg::t_req r;
        bit            fix;
        lkc_pkg::t_rsp e;
    } t_row;

    function automatic lkc_pkg::t_req mk(logic c, logic [30:0] t, logic [30:0] b,
                                         logic [31:0] h);
        lkc_pkg::t_req r;
        r.command = c; r.sst_id = t; r.blk_num = b; r.block_handle = h;
        return r;
    endfunction

    function automatic lkc_pkg::t_rsp rs(logic h, logic [31:0] f, logic [31:0] t,
                                         logic [31:0] n);
        lkc_pkg::t_rsp o;
        o.hit = h; o.found_handle = f; o.request_total = t; o.request_hits = n;
        return o;
    endfunction

    logic [30:0] pool_t[16];
    logic [30:0] pool_b[16];

    function automatic lkc_pkg::t_req random_request(int pool_n);
        lkc_pkg::t_req r;
        int k;
        r.command = 1'($urandom_range(1));
        r.block_handle = $urandom();
        if ($urandom_range(99) < 85) begin
            k = int'($urandom_range(pool_n - 1));
            r.sst_id = pool_t[k % 16];
            r.blk_num = pool_b[k % 16] + 31'(k / 16);
        end else begin
            r.sst_id = 31'($urandom());
            r.blk_num = 31'($urandom());
        end
        return r;
    endfunction

    initial begin
        t_row rows[$];
        lkc_pkg::t_req rr;
        errors = 0; wd_count = 0; n_gets = 0; n_hits_seen = 0; n_evict_cfg = 0;
        rst_n = 1'b0; start = 1'b0; req = '0;
        cfg_valid = 1'b0; cfg_index = lkc_pkg::CFG_THRESHOLD; cfg_data = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            m_valid[i] = 1'b0; m_rank[i] = 0; m_count[i] = '0;
            m_table[i] = '0; m_block[i] = '0; m_handle[i] = '0;
        end
        m_total = '0; m_hits = '0;
        m_thresh = lkc_pkg::THRESHOLD_RESET; m_cap = lkc_pkg::CAPACITY_RESET;
        for (int i = 0; i < 16; i++) begin
            pool_t[i] = (i == 0) ? 31'h7FFF_FFFF : 31'($urandom());
            pool_b[i] = (i == 1) ? 31'd0 : 31'($urandom());
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: miss on empty, extremes of key and handle, update, promotion
        rows.push_back('{mk(lkc_pkg::CMD_GET, 0, 0, 32'hFFFF_FFFF), 1, rs(0, 0, 1, 0)});
        rows.push_back('{mk(lkc_pkg::CMD_PUT, 0, 0, 32'hFFFF_FFFF), 1, rs(0, 0, 1, 0)});
        rows.push_back('{mk(lkc_pkg::CMD_GET, 0, 0, 0), 1, rs(1, 32'hFFFF_FFFF, 2, 1)});
        rows.push_back('{mk(lkc_pkg::CMD_PUT, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0), 1,
                         rs(0, 0, 2, 1)});
        rows.push_back('{mk(lkc_pkg::CMD_GET, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 5), 1,
                         rs(1, 0, 3, 2)});
        rows.push_back('{mk(lkc_pkg::CMD_PUT, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'hA5A5_5A5A),
                         0, '0});
        rows.push_back('{mk(lkc_pkg::CMD_GET, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0), 0, '0});
        rows.push_back('{mk(lkc_pkg::CMD_GET, 31'h7FFF_FFFF, 0, 0), 1, rs(0, 0, 5, 3)});
        rows.push_back('{mk(lkc_pkg::CMD_PUT, 1, 2, 32'h1234_5678), 0, '0});
        rows.push_back('{mk(lkc_pkg::CMD_PUT, 1, 3, 32'h8765_4321), 0, '0});
        foreach (rows[i]) send_request(rows[i].r, rows[i].fix, rows[i].e, 1'b0);
        drain_responses();

        // small capacity: evictions of probationary and protected entries
        write_reg(lkc_pkg::CFG_CAPACITY, 7'd2);
        write_reg(lkc_pkg::CFG_THRESHOLD, 7'd15);
        rows.delete();
        rows.push_back('{mk(lkc_pkg::CMD_PUT, 5, 5, 32'h55), 0, '0});
        rows.push_back('{mk(lkc_pkg::CMD_GET, 1, 2, 0), 0, '0});
        rows.push_back('{mk(lkc_pkg::CMD_GET, 0, 0, 0), 0, '0});
        rows.push_back('{mk(lkc_pkg::CMD_PUT, 6, 6, 32'h66), 0, '0});
        rows.push_back('{mk(lkc_pkg::CMD_GET, 5, 5, 0), 0, '0});
        foreach (rows[i]) send_request(rows[i].r, rows[i].fix, rows[i].e, 1'b0);
        drain_responses();
        write_reg(lkc_pkg::CFG_THRESHOLD, 7'd0);
        write_reg(lkc_pkg::CFG_CAPACITY, 7'd0);
        send_request(mk(lkc_pkg::CMD_PUT, 7, 7, 32'h77), 0, '0, 1'b0);
        send_request(mk(lkc_pkg::CMD_GET, 7, 7, 0), 0, '0, 1'b0);
        send_request(mk(lkc_pkg::CMD_GET, 6, 6, 0), 0, '0, 1'b0);
        drain_responses();

        // random phases across settings, capacity raised and lowered
        for (int ph = 0; ph < 8; ph++) begin
            logic [6:0] capv;
            int pool_n;
            case (ph)
                0: capv = 7'd64;
                1: capv = 7'd127;
                2: capv = 7'd1;
                default: capv = 7'($urandom_range(2, 70));
            endcase
            write_reg(lkc_pkg::CFG_CAPACITY, capv);
            write_reg(lkc_pkg::CFG_THRESHOLD, (ph == 1) ? 7'd15 : (ph == 2) ? 7'd1 :
                      7'($urandom_range(15)));
            n_evict_cfg++;
            pool_n = (capv < 60 && ph > 2) ? int'(capv) + 6 : 80;
            for (int n = 0; n < N_RANDOM / 8; n++) begin
                // a stretch without idle gaps in phase 3
                rr = random_request(pool_n);
                send_request(rr, 0, '0, ph != 3);
                if (n == 50 && ph == 4) drain_responses();
            end
            drain_responses();
        end

        $display("covered %0d gets (%0d hits), table walk, %0d random settings",
                 n_gets, n_hits_seen, n_evict_cfg);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("mismatches: %0d", errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
